/* sv/sip_pkg.sv */
// Shared types and widths for the segment intersection point pipeline.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

  // Coordinate width and the widths that follow from it
  localparam int COORD_BITS = 12;
  localparam int DIFF_BITS  = COORD_BITS + 1;       // endpoint differences
  localparam int PROD_BITS  = 2 * DIFF_BITS;        // product of two differences
  localparam int RAT_BITS   = 2 * COORD_BITS + 3;   // denominator and numerators
  localparam int NUM_BITS   = 3 * COORD_BITS + 3;   // scaled point numerator
  localparam int WIDE_BITS  = RAT_BITS + DIFF_BITS; // full numerator * difference

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [RAT_BITS-1:0]   rat_t;
  typedef logic signed [NUM_BITS-1:0]   num_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic        [NUM_BITS-1:0]   mag_t;
  typedef logic        [COORD_BITS-1:0] quot_t;

  // Input item
  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  // Result item
  typedef struct packed {
    logic   found;
    coord_t cross_x;
    coord_t cross_y;
  } cross_pt_t;

  // Stage 1: differences
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    diff_t  dax;
    diff_t  day;
    diff_t  dbx;
    diff_t  dby;
    diff_t  wx;
    diff_t  wy;
  } st_diff_t;

  // Stage 2: cross products
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    diff_t  dax;
    diff_t  day;
    prod_t  den_p;
    prod_t  den_m;
    prod_t  tn_p;
    prod_t  tn_m;
    prod_t  sn_p;
    prod_t  sn_m;
  } st_prod_t;

  // Stage 3: raw denominator and numerators
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    diff_t  dax;
    diff_t  day;
    rat_t   den;
    rat_t   tn;
    rat_t   sn;
  } st_rat_t;

  // Stage 4: sign-normalised, range checked
  typedef struct packed {
    logic   found;
    coord_t ax;
    coord_t ay;
    diff_t  dax;
    diff_t  day;
    rat_t   den;
    rat_t   tn;
  } st_norm_t;

  // Stage 5: numerator terms
  typedef struct packed {
    logic found;
    rat_t den;
    num_t ax_den;
    num_t ay_den;
    num_t tn_dax;
    num_t tn_day;
  } st_scale_t;

  // Stage 6: magnitudes and signs for division
  typedef struct packed {
    logic found;
    logic neg_x;
    logic neg_y;
    mag_t den;
    mag_t mag_x;
    mag_t mag_y;
  } st_abs_t;

  // Divider stages: partial remainders and quotients
  typedef struct packed {
    logic  found;
    logic  neg_x;
    logic  neg_y;
    mag_t  den;
    mag_t  rem_x;
    mag_t  rem_y;
    quot_t q_x;
    quot_t q_y;
  } st_div_t;

endpackage

`default_nettype wire

/* sv/sip_front.sv */
// Front end: differences, cross products, denominator/numerators, range check.
// Four register stages with a per-stage ready chain. Depends on sip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sip_front import sip_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  seg_pair_t  data_i,
  output logic       valid_o,
  input  wire        ready_i,
  output st_norm_t   data_o
);

  logic     v1_q, v2_q, v3_q, v4_q;
  logic     r1, r2, r3, r4;
  st_diff_t s1_d, s1_q;
  st_prod_t s2_d, s2_q;
  st_rat_t  s3_d, s3_q;
  st_norm_t s4_d, s4_q;

  // Stage holds when full and the next one cannot take
  assign r4 = !v4_q || ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  // Stage 1: endpoint differences
  always_comb begin
    s1_d.ax  = data_i.a_start_x;
    s1_d.ay  = data_i.a_start_y;
    s1_d.dax = diff_t'(data_i.a_end_x) - diff_t'(data_i.a_start_x);
    s1_d.day = diff_t'(data_i.a_end_y) - diff_t'(data_i.a_start_y);
    s1_d.dbx = diff_t'(data_i.b_end_x) - diff_t'(data_i.b_start_x);
    s1_d.dby = diff_t'(data_i.b_end_y) - diff_t'(data_i.b_start_y);
    s1_d.wx  = diff_t'(data_i.a_start_x) - diff_t'(data_i.b_start_x);
    s1_d.wy  = diff_t'(data_i.a_start_y) - diff_t'(data_i.b_start_y);
  end

  // Stage 2: six narrow products
  always_comb begin
    s2_d.ax    = s1_q.ax;
    s2_d.ay    = s1_q.ay;
    s2_d.dax   = s1_q.dax;
    s2_d.day   = s1_q.day;
    s2_d.den_p = s1_q.dby * s1_q.dax;
    s2_d.den_m = s1_q.dbx * s1_q.day;
    s2_d.tn_p  = s1_q.dbx * s1_q.wy;
    s2_d.tn_m  = s1_q.dby * s1_q.wx;
    s2_d.sn_p  = s1_q.dax * s1_q.wy;
    s2_d.sn_m  = s1_q.day * s1_q.wx;
  end

  // Stage 3: denominator and numerators
  always_comb begin
    s3_d.ax  = s2_q.ax;
    s3_d.ay  = s2_q.ay;
    s3_d.dax = s2_q.dax;
    s3_d.day = s2_q.day;
    s3_d.den = rat_t'(s2_q.den_p) - rat_t'(s2_q.den_m);
    s3_d.tn  = rat_t'(s2_q.tn_p) - rat_t'(s2_q.tn_m);
    s3_d.sn  = rat_t'(s2_q.sn_p) - rat_t'(s2_q.sn_m);
  end

  // Stage 4: make the denominator positive, then check both parameters
  always_comb begin
    rat_t nden, ntn, nsn;
    logic in_range;
    nden = s3_q.den[RAT_BITS-1] ? -s3_q.den : s3_q.den;
    ntn  = s3_q.den[RAT_BITS-1] ? -s3_q.tn  : s3_q.tn;
    nsn  = s3_q.den[RAT_BITS-1] ? -s3_q.sn  : s3_q.sn;
    in_range = !ntn[RAT_BITS-1] && (ntn <= nden) && !nsn[RAT_BITS-1] && (nsn <= nden);
    s4_d.found = (nden != '0) && in_range && !((ntn == '0) && (nsn == '0));
    s4_d.ax  = s3_q.ax;
    s4_d.ay  = s3_q.ay;
    s4_d.dax = s3_q.dax;
    s4_d.day = s3_q.day;
    s4_d.den = nden;
    s4_d.tn  = ntn;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) s1_q <= s1_d;
    if (r2 && v1_q)    s2_q <= s2_d;
    if (r3 && v2_q)    s3_q <= s3_d;
    if (r4 && v3_q)    s4_q <= s4_d;
  end

  assign valid_o = v4_q;
  assign data_o  = s4_q;

endmodule

`default_nettype wire

/* sv/sip_scale.sv */
// Scaling: forms the point numerators a_start*den + tn*dA and splits sign
// from magnitude for the divider. Two register stages. Depends on sip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sip_scale import sip_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  st_norm_t   data_i,
  output logic       valid_o,
  input  wire        ready_i,
  output st_abs_t    data_o
);

  logic      v5_q, v6_q;
  logic      r5, r6;
  st_scale_t s5_d, s5_q;
  st_abs_t   s6_d, s6_q;

  assign r6 = !v6_q || ready_i;
  assign r5 = !v5_q || r6;
  assign ready_o = r5;

  // Stage 5: four products; tn*dA is exact in its low bits for a found item
  always_comb begin
    wide_t tx, ty;
    tx = data_i.tn * data_i.dax;
    ty = data_i.tn * data_i.day;
    s5_d.found  = data_i.found;
    s5_d.den    = data_i.den;
    s5_d.ax_den = data_i.ax * data_i.den;
    s5_d.ay_den = data_i.ay * data_i.den;
    s5_d.tn_dax = tx[NUM_BITS-1:0];
    s5_d.tn_day = ty[NUM_BITS-1:0];
  end

  // Stage 6: sum, then sign and magnitude
  always_comb begin
    num_t nx, ny;
    nx = s5_q.ax_den + s5_q.tn_dax;
    ny = s5_q.ay_den + s5_q.tn_day;
    s6_d.found = s5_q.found;
    s6_d.neg_x = nx[NUM_BITS-1];
    s6_d.neg_y = ny[NUM_BITS-1];
    s6_d.den   = mag_t'(num_t'(s5_q.den));
    s6_d.mag_x = mag_t'(nx[NUM_BITS-1] ? -nx : nx);
    s6_d.mag_y = mag_t'(ny[NUM_BITS-1] ? -ny : ny);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (r5) v5_q <= valid_i;
      if (r6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r5 && valid_i) s5_q <= s5_d;
    if (r6 && v5_q)    s6_q <= s6_d;
  end

  assign valid_o = v6_q;
  assign data_o  = s6_q;

endmodule

`default_nettype wire

/* sv/sip_div.sv */
// Pipelined restoring divider: one quotient bit per stage for x and y,
// COORD_BITS stages, each a compare and subtract. Depends on sip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sip_div import sip_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  st_abs_t    data_i,
  output logic       valid_o,
  input  wire        ready_i,
  output st_div_t    data_o
);

  localparam int NSTG    = COORD_BITS;
  localparam int QB_BITS = $clog2(NSTG);

  typedef logic [QB_BITS-1:0] qidx_t;

  logic    vld_q [NSTG];
  logic    rdy   [NSTG+1];
  st_div_t cur   [NSTG];
  st_div_t nxt   [NSTG];
  st_div_t stg_q [NSTG];

  // One restoring step on both coordinates at quotient bit b
  function automatic st_div_t div_step(st_div_t s, qidx_t b);
    st_div_t r;
    mag_t    trial;
    r     = s;
    trial = s.den << b;
    if (s.rem_x >= trial) begin
      r.rem_x  = s.rem_x - trial;
      r.q_x[b] = 1'b1;
    end
    if (s.rem_y >= trial) begin
      r.rem_y  = s.rem_y - trial;
      r.q_y[b] = 1'b1;
    end
    return r;
  endfunction

  // Entry into the first stage
  always_comb begin
    cur[0].found = data_i.found;
    cur[0].neg_x = data_i.neg_x;
    cur[0].neg_y = data_i.neg_y;
    cur[0].den   = data_i.den;
    cur[0].rem_x = data_i.mag_x;
    cur[0].rem_y = data_i.mag_y;
    cur[0].q_x   = '0;
    cur[0].q_y   = '0;
  end

  assign rdy[NSTG] = ready_i;
  assign ready_o   = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign cur[k] = stg_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];
    assign nxt[k] = div_step(cur[k], qidx_t'(NSTG - 1 - k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stg_q[k] <= nxt[k];
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign data_o  = stg_q[NSTG-1];

  // A found item's quotients always fit within COORD_BITS bits: each remainder ends below the denominator
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && data_o.found) |-> (data_o.rem_x < data_o.den) && (data_o.rem_y < data_o.den))
    else $error("divider remainder not below denominator");

endmodule

`default_nettype wire

/* sv/segment_intersection_point.sv */
// Pipeline: 4 front stages, 2 scaling stages, COORD_BITS = 12 divider stages and
// 1 output register. Throughput: one item per cycle while out_ready_i is high;
// each stage stalls only when it is full and its successor cannot take it, so
// bubbles are squeezed out under back-pressure.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// Depends on sip_pkg, sip_front, sip_scale and sip_div.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_point import sip_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  seg_pair_t  in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output cross_pt_t  out_data_o
);

  logic      fr_valid, fr_ready;
  st_norm_t  fr_data;
  logic      sc_valid, sc_ready;
  st_abs_t   sc_data;
  logic      dv_valid, dv_ready;
  st_div_t   dv_data;
  logic      out_valid_q;
  cross_pt_t out_d, out_q;

  sip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  sip_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_data),
    .valid_o (sc_valid),
    .ready_i (sc_ready),
    .data_o  (sc_data)
  );

  sip_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .data_i  (sc_data),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .data_o  (dv_data)
  );

  // Output register: apply signs, zero the point when nothing was found
  assign dv_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.found   = dv_data.found;
    out_d.cross_x = '0;
    out_d.cross_y = '0;
    if (dv_data.found) begin
      out_d.cross_x = coord_t'(dv_data.neg_x ? -dv_data.q_x : dv_data.q_x);
      out_d.cross_y = coord_t'(dv_data.neg_y ? -dv_data.q_y : dv_data.q_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dv_ready) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready && dv_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An empty output register means the whole ready chain is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  // A miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.cross_x == '0) &&
                                          (out_data_o.cross_y == '0))
    else $error("point not zero on a miss");

  // A result taken from the output register is replaced or the register empties
  a_out_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !dv_valid) |=> !out_valid_o)
    else $error("output register kept a transferred result");

endmodule

`default_nettype wire
